[rtl/core/drfp_pkg.sv]
// Package for the display reply frame parser: payload structs, codes, constants.
// No dependencies; every other file of the block imports it.
package drfp_pkg;

  localparam int EventQueueDepthDefault = 8;

  typedef enum logic [1:0] {
    CMD_RX_BYTE   = 2'd0,
    CMD_POP_EVENT = 2'd1,
    CMD_ARM_DATA  = 2'd2,
    CMD_ARM_RESP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_POPPED    = 4'd1,
    ST_EMPTY     = 4'd2,
    ST_QUEUED    = 4'd3,
    ST_DROPPED   = 4'd4,
    ST_RESPONSE  = 4'd5,
    ST_NUMBER    = 4'd6,
    ST_STRING    = 4'd7,
    ST_BAD_NUM   = 4'd8,
    ST_DISCARDED = 4'd9
  } status_t;

  localparam logic [7:0] BYTE_EVENT  = 8'h65;
  localparam logic [7:0] BYTE_STRING = 8'h70;
  localparam logic [7:0] BYTE_NUMBER = 8'h71;
  localparam logic [7:0] BYTE_FF     = 8'hff;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [7:0] capture_len;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [55:0] event_data;
    logic [3:0]  event_count;
    logic [31:0] response_data;
    logic [31:0] number_value;
    logic [7:0]  string_byte;
    logic        string_byte_valid;
    logic [7:0]  string_length;
  } out_item_t;

endpackage

[rtl/core/display_reply_frame_parser.sv]
// Top level of the display reply frame parser: input queue plus parser back end.
// Depends on drfp_pkg, drfp_front and drfp_back.
//
// Usage: each input request carries a command (receive byte, pop event, arm
// data capture, arm response capture), a byte and a capture length. It is
// pushed with in_push while in_full is low. Every request yields exactly one
// result on the out_ side, shown while out_empty is low and taken with out_pop.
// A request passes through the input queue, then the parser, whose result
// register feeds the outputs. Throughput is one request per cycle while the
// result register is free or being popped. When the receiver
// stalls, the result register holds and the two-entry input queue fills, then
// in_full rises. Synchronous active-low reset empties both queues, clears the
// event FIFO count, disarms both captures and returns to message mode; the
// block accepts requests from the first cycle after reset.
module display_reply_frame_parser #(
  parameter int EventQueueDepth = drfp_pkg::EventQueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  drfp_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output drfp_pkg::out_item_t out_item
);
  import drfp_pkg::*;

  logic     req_valid, req_take;
  in_item_t req_item;

  drfp_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .req_valid, .req_item, .req_take
  );

  drfp_back #(.EventQueueDepth(EventQueueDepth)) u_back (
    .clk, .rst_n, .req_valid, .req_item, .req_take,
    .out_empty, .out_pop, .out_item
  );
endmodule

[rtl/core/drfp_front.sv]
// Front part: input queue stage that accepts a request and holds it for the parser.
// Depends on drfp_pkg.
module drfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  drfp_pkg::in_item_t in_item,
  output logic              req_valid,
  output drfp_pkg::in_item_t req_item,
  input  logic              req_take
);
  import drfp_pkg::*;

  // Two-entry queue so each side stalls on its own at full rate.
  in_item_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign in_full   = cnt_r == 2'd2;
  assign req_valid = cnt_r != 2'd0;
  assign req_item  = mem_r[rptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= in_item;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

[rtl/core/drfp_back.sv]
// Back part: the frame parser state, event FIFO and result register.
// Depends on drfp_pkg.
module drfp_back #(
  parameter int EventQueueDepth = drfp_pkg::EventQueueDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  drfp_pkg::in_item_t req_item,
  output logic               req_take,
  output logic               out_empty,
  input  logic               out_pop,
  output drfp_pkg::out_item_t out_item
);
  import drfp_pkg::*;

  localparam int QW = $clog2(EventQueueDepth);
  localparam int CW = $clog2(EventQueueDepth + 1);

  typedef enum logic [1:0] {
    MODE_MSG, MODE_STRING, MODE_NUMBER, MODE_DISCARD
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [1:0]    run_r, run_nxt;
  logic [55:0]   hold_r, hold_nxt;
  logic [2:0]    fcnt_r, fcnt_nxt;
  logic [55:0]   queue_mem [EventQueueDepth];
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] qcnt_r, qcnt_nxt;
  logic          darm_r, darm_nxt, rarm_r, rarm_nxt;
  logic [7:0]    dlim_r, dlim_nxt, dcnt_r, dcnt_nxt;
  logic [31:0]   num_r, num_nxt;
  logic          qwrite;
  out_item_t     res, res_r;
  logic          res_valid_r;
  logic          step;

  // Output register: the next request is processed only when no result waits or the waiting one is popped.
  assign req_take  = req_valid && (!res_valid_r || out_pop);
  assign step      = req_take;
  assign out_empty = !res_valid_r;
  assign out_item  = res_r;

  // Step logic, one request per cycle while the result register can take a result.
  always_comb begin
    logic [55:0] h;
    logic [2:0]  fc;
    logic [1:0]  rn;
    mode_t       m;
    h = hold_r; fc = fcnt_r; rn = run_r; m = mode_r;
    mode_nxt = mode_r; run_nxt = run_r; hold_nxt = hold_r; fcnt_nxt = fcnt_r;
    head_nxt = head_r; tail_nxt = tail_r; qcnt_nxt = qcnt_r;
    darm_nxt = darm_r; rarm_nxt = rarm_r; dlim_nxt = dlim_r; dcnt_nxt = dcnt_r;
    num_nxt = num_r; qwrite = 1'b0;
    res = '0;
    if (m == MODE_DISCARD && !darm_r) m = MODE_MSG;
    mode_nxt = m;
    unique case (cmd_t'(req_item.command))
      CMD_RX_BYTE: begin
        if (m == MODE_MSG) begin
          if (req_item.rx_byte == BYTE_STRING || req_item.rx_byte == BYTE_NUMBER) begin
            fcnt_nxt = '0; hold_nxt = '0; run_nxt = '0; dcnt_nxt = '0;
            if (!darm_r) mode_nxt = MODE_DISCARD;
            else mode_nxt = (req_item.rx_byte == BYTE_STRING) ? MODE_STRING : MODE_NUMBER;
          end else if (req_item.rx_byte == BYTE_FF || fc < 3'd4) begin
            // Append a byte, dropping the oldest when seven are held.
            if (fc == 3'd7) begin
              h = {8'h00, h[55:8]};
              fc = 3'd6;
            end
            h[fc*8 +: 8] = req_item.rx_byte;
            fc = fc + 3'd1;
            hold_nxt = h; fcnt_nxt = fc;
            if (req_item.rx_byte != BYTE_FF) run_nxt = '0;
            else if (rn == 2'd2) begin
              // Frame end.
              if (fc == 3'd7 && h[7:0] == BYTE_EVENT) begin
                res.event_data = h;
                if (qcnt_r < CW'(EventQueueDepth)) begin
                  qwrite   = 1'b1;
                  tail_nxt = (tail_r == QW'(EventQueueDepth - 1)) ? '0 : tail_r + QW'(1);
                  qcnt_nxt = qcnt_r + CW'(1);
                  res.status = ST_QUEUED;
                end else res.status = ST_DROPPED;
              end else if (fc == 3'd4 && rarm_r) begin
                res.status = ST_RESPONSE;
                res.response_data = h[31:0];
                rarm_nxt = 1'b0;
              end else res.status = ST_DISCARDED;
              fcnt_nxt = '0; hold_nxt = '0; run_nxt = '0;
            end else run_nxt = rn + 2'd1;
          end else run_nxt = '0;
        end else if (req_item.rx_byte == BYTE_FF) begin
          if (rn == 2'd2) begin
            unique case (m)
              MODE_NUMBER: begin
                if (dcnt_r == 8'd4) begin
                  res.status = ST_NUMBER;
                  res.number_value = num_r;
                end else res.status = ST_BAD_NUM;
              end
              MODE_STRING: begin
                res.status = ST_STRING;
                res.string_length = dcnt_r;
              end
              default: res.status = ST_DISCARDED;
            endcase
            darm_nxt = 1'b0; dcnt_nxt = '0; run_nxt = '0; mode_nxt = MODE_MSG;
          end else run_nxt = rn + 2'd1;
        end else begin
          run_nxt = '0;
          if (m == MODE_NUMBER) begin
            if (dcnt_r < 8'd4) num_nxt[dcnt_r[1:0]*8 +: 8] = req_item.rx_byte;
            if (dcnt_r != 8'd255) dcnt_nxt = dcnt_r + 8'd1;
          end else if (m == MODE_STRING) begin
            if (dlim_r != 8'd0 && dcnt_r < dlim_r - 8'd1) begin
              dcnt_nxt = dcnt_r + 8'd1;
              res.string_byte = req_item.rx_byte;
              res.string_byte_valid = 1'b1;
            end
          end
        end
      end
      CMD_POP_EVENT: begin
        if (qcnt_r != '0) begin
          res.status = ST_POPPED;
          res.event_data = queue_mem[head_r];
          head_nxt = (head_r == QW'(EventQueueDepth - 1)) ? '0 : head_r + QW'(1);
          qcnt_nxt = qcnt_r - CW'(1);
        end else res.status = ST_EMPTY;
      end
      CMD_ARM_DATA: begin
        if (req_item.capture_len != 8'd0) begin
          darm_nxt = 1'b1; dlim_nxt = req_item.capture_len;
          dcnt_nxt = '0; fcnt_nxt = '0; hold_nxt = '0;
        end
      end
      default: rarm_nxt = 1'b1;
    endcase
    res.event_count = 4'(qcnt_nxt);
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (step && qwrite) queue_mem[tail_r] <= res.event_data;
    if (step) begin
      res_r  <= res;
      hold_r <= hold_nxt;
      num_r  <= num_nxt;
    end
    if (!rst_n) begin
      mode_r <= MODE_MSG; run_r <= '0; fcnt_r <= '0; head_r <= '0; tail_r <= '0;
      qcnt_r <= '0; darm_r <= 1'b0; rarm_r <= 1'b0; dlim_r <= '0; dcnt_r <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r <= mode_nxt; run_r <= run_nxt; fcnt_r <= fcnt_nxt;
        head_r <= head_nxt; tail_r <= tail_nxt; qcnt_r <= qcnt_nxt;
        darm_r <= darm_nxt; rarm_r <= rarm_nxt; dlim_r <= dlim_nxt; dcnt_r <= dcnt_nxt;
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/drfp_checker.sv]
// Port-level checker for the display reply frame parser, bound to the top level.
// Depends on drfp_pkg.
module drfp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input drfp_pkg::out_item_t out_item
);
  import drfp_pkg::*;

  // Status codes stay within the defined set.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.status <= ST_DISCARDED) else $error("bad status");

  // Queue count never exceeds 8, the default FIFO depth.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.event_count <= 4'd8) else $error("bad count");

  // A waiting result holds while not popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item)) else $error("result lost");

  // After reset nothing is waiting.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full) else $error("reset state");
endmodule

bind display_reply_frame_parser drfp_checker u_checker (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_item
);
